>>> sv/cfla_pkg.sv
// Shared types and constants for the checked free-list allocator.
`default_nettype none
package cfla_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 1024;
	localparam int unsigned RESET_COUNT     = 1024;
	localparam int unsigned IDX_FIELD_W     = 10;
	localparam int unsigned CNT_FIELD_W     = 11;
	localparam int unsigned STATUS_W        = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_EXHAUSTED    = 3'd1,
		ST_BAD_INDEX    = 3'd2,
		ST_MAPPED       = 3'd3,
		ST_ALREADY_FREE = 3'd4,
		ST_OVERFLOW     = 3'd5
	} status_t;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// outcome of one request
	typedef struct packed {
		status_t status;
		logic    pop;
		logic    fresh;
		logic    push;
	} decision_t;

endpackage
`default_nettype wire

>>> sv/checked_free_list_allocator.sv
// Checked free-list allocator: LIFO free-index stack with per-entry in-use checks.
// A request is accepted in the idle state, which reads the stack RAM at the top of
// stack and the in-use RAM at the release index; the execute state decides
// through the check unit, updates both RAMs and the depth, and loads the result
// register. One request is in flight at a time; in_stall is high in the execute
// state, which holds while a finished result cannot yet be loaded because the
// previous one waits. A new request is taken while a result sits unclaimed in the
// output register. Reset and a write of the entry count reinitialize the pool: a
// counter of indices handed out from the initial fill stands in for the filled
// stack and the cleared in-use marks, so there is no clearing pass.
`default_nettype none
module checked_free_list_allocator
	import cfla_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CNT_FIELD_W-1:0] cfg_wr_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   operation,
	input  wire logic [IDX_FIELD_W-1:0] entry_index,
	input  wire logic                   still_mapped,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic      [STATUS_W-1:0]    status,
	output logic      [IDX_FIELD_W-1:0] granted_index,
	output logic      [CNT_FIELD_W-1:0] free_entries
);

	localparam int unsigned IW = $clog2(MAX_ENTRIES);
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned RST_CNT = (RESET_COUNT < MAX_ENTRIES) ? RESET_COUNT : MAX_ENTRIES;

	state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic [CW-1:0] depth_q;
	logic [CW-1:0] fresh_q;

	op_t                    op_q;
	logic [IDX_FIELD_W-1:0] idx_q;
	logic                   mapped_q;

	logic                   out_valid_q;
	logic [STATUS_W-1:0]    status_q;
	logic [IDX_FIELD_W-1:0] granted_q;
	logic [CNT_FIELD_W-1:0] free_q;

	logic          accept;
	logic          out_free;
	logic          commit;
	logic [CW-1:0] count_d;
	logic [31:0]   cfg_x;
	logic [31:0]   in_idx_x;
	logic [31:0]   rel_idx_x;
	logic [31:0]   grant_x;
	logic [31:0]   depth_x;
	logic [IW-1:0] rel_idx;
	logic [IW-1:0] grant_idx;
	logic [CW-1:0] depth_dec;
	logic [CW-1:0] depth_d;
	logic [IW-1:0] stack_rdata;
	logic          busy_rdata;
	decision_t     dec;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign commit   = (state_q == S_EXEC) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// entry count write: zero holds at one, above the pool saturates
	assign cfg_x = 32'(cfg_wr_data);
	always_comb begin
		priority if (cfg_x == 32'd0) begin
			count_d = CW'(1);
		end else if (cfg_x > 32'(MAX_ENTRIES)) begin
			count_d = CW'(MAX_ENTRIES);
		end else begin
			count_d = cfg_x[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_t'(operation);
			idx_q    <= entry_index;
			mapped_q <= still_mapped;
		end
	end

	assign in_idx_x  = 32'(entry_index);
	assign rel_idx_x = 32'(idx_q);
	assign rel_idx   = rel_idx_x[IW-1:0];
	assign depth_dec = depth_q - CW'(1);

	cfla_ram #(
		.WIDTH(IW),
		.DEPTH(MAX_ENTRIES)
	) u_stack_ram (
		.clk  (clk),
		.we   (commit && dec.push),
		.waddr(depth_q[IW-1:0]),
		.wdata(rel_idx),
		.re   (accept),
		.raddr(depth_dec[IW-1:0]),
		.rdata(stack_rdata)
	);

	cfla_ram #(
		.WIDTH(1),
		.DEPTH(MAX_ENTRIES)
	) u_busy_ram (
		.clk  (clk),
		.we   (commit && (dec.pop || dec.push)),
		.waddr(dec.pop ? grant_idx : rel_idx),
		.wdata(dec.pop),
		.re   (accept),
		.raddr(in_idx_x[IW-1:0]),
		.rdata(busy_rdata)
	);

	cfla_unit #(
		.CW(CW)
	) u_unit (
		.op    (op_q),
		.idx   (idx_q),
		.mapped(mapped_q),
		.busy  (busy_rdata),
		.count (count_q),
		.depth (depth_q),
		.fresh (fresh_q),
		.dec   (dec)
	);

	// an untouched slot at stack position p holds count-1-p, which equals fresh_q
	assign grant_idx = dec.fresh ? fresh_q[IW-1:0] : stack_rdata;

	always_comb begin
		priority if (dec.pop) begin
			depth_d = depth_dec;
		end else if (dec.push) begin
			depth_d = depth_q + CW'(1);
		end else begin
			depth_d = depth_q;
		end
	end

	assign grant_x = dec.pop ? 32'(grant_idx) : 32'd0;
	assign depth_x = 32'(depth_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(RST_CNT);
			depth_q <= CW'(RST_CNT);
			fresh_q <= '0;
		end else if (cfg_wr_en) begin
			count_q <= count_d;
			depth_q <= count_d;
			fresh_q <= '0;
		end else if (commit) begin
			depth_q <= depth_d;
			if (dec.fresh) begin
				fresh_q <= fresh_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q  <= dec.status;
			granted_q <= grant_x[IDX_FIELD_W-1:0];
			free_q    <= depth_x[CNT_FIELD_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_index = granted_q;
	assign free_entries  = free_q;

endmodule
`default_nettype wire

>>> sv/cfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cfla_ram
	import cfla_pkg::*;
#(
	parameter int unsigned WIDTH = 10,
	parameter int unsigned DEPTH = MAX_ENTRIES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/cfla_unit.sv
// Request check unit: ordered compares that decide the outcome of one request.
`default_nettype none
module cfla_unit
	import cfla_pkg::*;
#(
	parameter int unsigned CW = 11
) (
	input  wire op_t                    op,
	input  wire logic [IDX_FIELD_W-1:0] idx,
	input  wire logic                   mapped,
	input  wire logic                   busy,
	input  wire logic [CW-1:0]          count,
	input  wire logic [CW-1:0]          depth,
	input  wire logic [CW-1:0]          fresh,
	output decision_t                   dec
);

	localparam int unsigned XW = (CW > IDX_FIELD_W) ? CW : IDX_FIELD_W;

	logic [XW-1:0] idx_x;
	logic [XW-1:0] count_x;
	logic [XW-1:0] fresh_x;
	logic [CW:0]   sum;

	assign idx_x   = XW'(idx);
	assign count_x = XW'(count);
	assign fresh_x = XW'(fresh);
	assign sum     = (CW+1)'(depth) + (CW+1)'(fresh);

	always_comb begin
		dec = '{status: ST_OK, pop: 1'b0, fresh: 1'b0, push: 1'b0};
		unique case (op)
			OP_ALLOC: begin
				if (depth == '0) begin
					dec.status = ST_EXHAUSTED;
				end else begin
					dec.pop   = 1'b1;
					// top of stack still in the untouched initial region
					dec.fresh = (sum == (CW+1)'(count));
				end
			end
			OP_RELEASE: begin
				priority if (idx_x >= count_x) begin
					dec.status = ST_BAD_INDEX;
				end else if (mapped) begin
					dec.status = ST_MAPPED;
				end else if (!(idx_x < fresh_x && busy)) begin
					dec.status = ST_ALREADY_FREE;
				end else if (depth >= count) begin
					dec.status = ST_OVERFLOW;
				end else begin
					dec.push = 1'b1;
				end
			end
			default: begin
				dec.status = ST_OK;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> sim/tb_checked_free_list_allocator.sv
// Testbench for the checked free-list allocator: predicted results checked per item.
`default_nettype none
module tb_checked_free_list_allocator
	import cfla_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_MAX    = 1024;
	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		status_t          status;
		logic [IDX_FIELD_W-1:0] granted;
		logic [CNT_FIELD_W-1:0] free;
	} alloc_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CNT_FIELD_W-1:0] cfg_wr_data;
	logic                   in_valid;
	logic                   in_stall;
	logic                   operation;
	logic [IDX_FIELD_W-1:0] entry_index;
	logic                   still_mapped;
	logic                   out_valid;
	logic                   out_stall;
	logic [STATUS_W-1:0]    status;
	logic [IDX_FIELD_W-1:0] granted_index;
	logic [CNT_FIELD_W-1:0] free_entries;

	// predicted pool state
	logic [IDX_FIELD_W-1:0] free_list [POOL_MAX];
	logic                   busy [POOL_MAX];
	logic [CNT_FIELD_W-1:0] free_depth;
	logic [CNT_FIELD_W-1:0] pool_count;

	alloc_result_t          pending_results [$];
	logic [IDX_FIELD_W-1:0] held_slots [$];
	int                     mismatches;
	int                     cycle_count;
	bit                     idle_on;
	logic                   hold_req;

	checked_free_list_allocator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.entry_index  (entry_index),
		.still_mapped (still_mapped),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.granted_index(granted_index),
		.free_entries (free_entries)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic void load_pool(logic [CNT_FIELD_W-1:0] value);
		if (value == 0)
			pool_count = CNT_FIELD_W'(1);
		else if (value > POOL_MAX)
			pool_count = CNT_FIELD_W'(POOL_MAX);
		else
			pool_count = value;
		for (int k = 0; k < POOL_MAX; k++) begin
			busy[k] = 1'b0;
			free_list[k] = (k < pool_count) ? IDX_FIELD_W'(pool_count - 1 - k) : '0;
		end
		free_depth = pool_count;
		held_slots.delete();
	endfunction

	function automatic alloc_result_t predict_request(op_t op, logic [IDX_FIELD_W-1:0] idx,
			logic mapped);
		alloc_result_t r;
		r.status = ST_OK;
		r.granted = '0;
		if (op == OP_ALLOC) begin
			if (free_depth == 0) begin
				r.status = ST_EXHAUSTED;
			end else begin
				free_depth = free_depth - CNT_FIELD_W'(1);
				r.granted = free_list[free_depth];
				busy[r.granted] = 1'b1;
			end
		end else if ({1'b0, idx} >= pool_count) begin
			r.status = ST_BAD_INDEX;
		end else if (mapped) begin
			r.status = ST_MAPPED;
		end else if (!busy[idx]) begin
			r.status = ST_ALREADY_FREE;
		end else if (free_depth >= pool_count) begin
			r.status = ST_OVERFLOW;
		end else begin
			busy[idx] = 1'b0;
			free_list[free_depth] = idx;
			free_depth = free_depth + CNT_FIELD_W'(1);
		end
		r.free = free_depth;
		return r;
	endfunction

	task automatic send_item(op_t op, logic [IDX_FIELD_W-1:0] idx, logic mapped);
		bit took;
		alloc_result_t r;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		entry_index <= idx;
		still_mapped <= mapped;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		r = predict_request(op, idx, mapped);
		pending_results.push_back(r);
		if (op == OP_ALLOC && r.status == ST_OK)
			held_slots.push_back(r.granted);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(logic [CNT_FIELD_W-1:0] value);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		load_pool(value);
	endtask

	// mostly well-formed traffic: allocates, and releases of entries we hold
	task automatic random_request(int alloc_pct);
		int p;
		logic [IDX_FIELD_W-1:0] idx;
		logic mapped;
		if ($urandom_range(0, 99) < alloc_pct) begin
			send_item(OP_ALLOC, IDX_FIELD_W'($urandom), 1'($urandom));
		end else if (held_slots.size() != 0 && $urandom_range(0, 9) < 7) begin
			p = $urandom_range(0, held_slots.size() - 1);
			idx = held_slots[p];
			mapped = ($urandom_range(0, 9) == 0);
			if (!mapped)
				held_slots.delete(p);
			send_item(OP_RELEASE, idx, mapped);
		end else begin
			send_item(OP_RELEASE, IDX_FIELD_W'($urandom), 1'($urandom_range(0, 3) == 0));
		end
	endtask

	task automatic test_directed();
		send_item(OP_RELEASE, 10'd1023, 1'b0);
		send_item(OP_ALLOC, 10'd1023, 1'b1);
		send_item(OP_ALLOC, 10'd0, 1'b0);
		send_item(OP_RELEASE, 10'd0, 1'b1);
		send_item(OP_RELEASE, 10'd0, 1'b0);
		send_item(OP_RELEASE, 10'd0, 1'b0);
		send_item(OP_ALLOC, 10'd512, 1'b0);
		send_item(OP_RELEASE, 10'd1, 1'b0);
		// zero count holds at one entry
		write_count(11'd0);
		send_item(OP_ALLOC, 10'd0, 1'b0);
		send_item(OP_ALLOC, 10'd0, 1'b0);
		send_item(OP_RELEASE, 10'd1, 1'b0);
		send_item(OP_RELEASE, 10'd1023, 1'b1);
		send_item(OP_RELEASE, 10'd0, 1'b1);
		send_item(OP_RELEASE, 10'd0, 1'b0);
		send_item(OP_ALLOC, 10'd0, 1'b0);
		// count above the pool size saturates
		write_count(11'd2047);
		send_item(OP_ALLOC, 10'd1023, 1'b0);
		send_item(OP_RELEASE, 10'd1023, 1'b1);
		send_item(OP_RELEASE, 10'd1023, 1'b0);
		write_count(11'd2);
		send_item(OP_ALLOC, 10'd0, 1'b0);
		send_item(OP_ALLOC, 10'd0, 1'b0);
		send_item(OP_ALLOC, 10'd0, 1'b0);
		send_item(OP_RELEASE, 10'd2, 1'b0);
	endtask

	// fill deep enough that granted indices pass 512
	task automatic test_deep_pool();
		idle_on = 1;
		write_count(11'd1024);
		repeat (700) random_request(90);
	endtask

	task automatic test_random_pools();
		logic [CNT_FIELD_W-1:0] counts [8];
		counts = '{11'd1, 11'd2, 11'd0, 11'd2047, 11'd1025, 11'd0, 11'd0, 11'd0};
		for (int k = 5; k < 8; k++)
			counts[k] = CNT_FIELD_W'($urandom_range(3, 64));
		foreach (counts[k]) begin
			write_count(counts[k]);
			repeat (110) random_request(55);
		end
	endtask

	task automatic test_backpressure();
		write_count(11'd8);
		hold_req <= 1'b1;
		repeat (30) random_request(60);
	endtask

	task automatic test_quiet_tail();
		idle_on = 0;
		write_count(CNT_FIELD_W'($urandom_range(1, 32)));
		repeat (80) random_request(55);
	endtask

	// receiver: short random stalls, one long counted hold on request
	initial begin
		out_stall = 1'b0;
		hold_req = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(0, 2)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic report(string what, int exp_v, int act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
	endtask

	always @(negedge clk) begin
		alloc_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report("unexpected item, status", -1, status);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status)
					report("status", e.status, status);
				if (granted_index !== e.granted)
					report("granted_index", e.granted, granted_index);
				if (free_entries !== e.free)
					report("free_entries", e.free, free_entries);
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		operation = 1'b0;
		entry_index = '0;
		still_mapped = 1'b0;
		idle_on = 0;
		mismatches = 0;
		cycle_count = 0;
		load_pool(CNT_FIELD_W'(RESET_COUNT));
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_deep_pool();
		test_random_pools();
		test_backpressure();
		test_quiet_tail();
		drain_results();
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
